@@ hw/rtl/i2cbm_pkg.sv @@
// Package for the I2C bit-level master.
// Holds the phase encoding, command codes, reset constants and the result item type.
// No dependencies.
package i2cbm_pkg;

  // Config register reset value and field widths
  localparam logic [15:0] HOLD_RESET = 16'd5;
  localparam int unsigned HOLD_W     = 16;
  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned REQ_W      = 3;

  // Command codes carried by req_type
  localparam logic [REQ_W-1:0] REQ_NONE  = 3'd0;
  localparam logic [REQ_W-1:0] REQ_START = 3'd1;
  localparam logic [REQ_W-1:0] REQ_WRITE = 3'd2;
  localparam logic [REQ_W-1:0] REQ_READ  = 3'd3;
  localparam logic [REQ_W-1:0] REQ_STOP  = 3'd4;

  // Number of data bits in one byte transfer
  localparam logic [3:0] BITS_PER_BYTE = 4'd8;

  // Bus sequencer phases
  typedef enum logic [4:0] {
    P_IDLE   = 5'd0,
    ST_SDA1  = 5'd1,
    ST_SCL1  = 5'd2,
    ST_W1    = 5'd3,
    ST_SDA0  = 5'd4,
    ST_W2    = 5'd5,
    ST_SCL0  = 5'd6,
    WR_BIT   = 5'd7,
    WR_SCL1  = 5'd8,
    WR_W     = 5'd9,
    WR_SCL0  = 5'd10,
    WR_REL   = 5'd11,
    WR_ASCL1 = 5'd12,
    WR_AW    = 5'd13,
    WR_ASCL0 = 5'd14,
    WR_TW    = 5'd15,
    RD_SCL1  = 5'd16,
    RD_W     = 5'd17,
    RD_SCL0  = 5'd18,
    RD_ACK   = 5'd19,
    RD_ASCL1 = 5'd20,
    RD_AW    = 5'd21,
    RD_ASCL0 = 5'd22,
    RD_REL   = 5'd23,
    SP_SCL0  = 5'd24,
    SP_SDA0  = 5'd25,
    SP_W1    = 5'd26,
    SP_SCL1  = 5'd27,
    SP_W2    = 5'd28,
    SP_SDA1  = 5'd29
  } phase_t;

  // One result item
  typedef struct packed {
    logic              scl_out;
    logic              sda_out;
    logic              ready_res;
    logic              done_res;
    logic [BYTE_W-1:0] rx_byte;
    logic              ack_seen;
  } result_t;

endpackage

@@ hw/rtl/i2c_bit_level_master.sv @@
// Top level of the I2C bit-level master.
// Holds the hold_ticks register and the output register with skid stage.
// Depends on i2cbm_pkg and i2cbm_core.

// Each input item is one bus tick and yields exactly one result item giving the
// SCL/SDA levels for that tick, the ready and done flags, the last read byte and the
// last write's acknowledge. One item is taken every clock cycle while in_stall is low: the
// sequencer step is a single pass of logic from the phase register to the result register,
// and a two-entry output buffer keeps input flowing for one more item while the output stalls.
// A command (req_type) is taken only on a tick where the previous result showed
// ready; its first pin move shows in the result of that same tick. Delayed bus
// phases last hold_ticks ticks (0 counts as 1); hold_ticks resets to 5.
module i2c_bit_level_master (
  input  logic                         clk,
  input  logic                         rst,
  // Input item channel
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [i2cbm_pkg::REQ_W-1:0]  req_type,
  input  logic [i2cbm_pkg::BYTE_W-1:0] tx_byte,
  input  logic                         send_ack,
  input  logic                         sda_in,
  // Configuration write
  input  logic                         cfg_we,
  input  logic [i2cbm_pkg::HOLD_W-1:0] cfg_wdata,
  // Result item channel
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic                         scl_out,
  output logic                         sda_out,
  output logic                         ready_res,
  output logic                         done_res,
  output logic [i2cbm_pkg::BYTE_W-1:0] rx_byte,
  output logic                         ack_seen
);
  import i2cbm_pkg::*;

  logic [HOLD_W-1:0] hold_ticks;
  logic              accept;
  result_t           res;
  result_t           out_item;
  result_t           skid_item;
  logic              skid_valid;

  // Hold time register
  always_ff @(posedge clk) begin
    if (rst) begin
      hold_ticks <= HOLD_RESET;
    end else if (cfg_we) begin
      hold_ticks <= cfg_wdata;
    end
  end

  assign in_stall = skid_valid;
  assign accept   = in_valid & ~skid_valid;

  i2cbm_core u_core (
    .clk        (clk),
    .rst        (rst),
    .tick       (accept),
    .req_type   (req_type),
    .tx_byte    (tx_byte),
    .send_ack   (send_ack),
    .sda_in     (sda_in),
    .hold_ticks (hold_ticks),
    .res        (res)
  );

  // Output register and skid stage
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || !out_stall) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= accept;
      end
    end else if (accept) begin
      skid_valid <= 1'b1;
    end
  end

  // Payload moves without reset
  always_ff @(posedge clk) begin
    if (!out_valid || !out_stall) begin
      if (skid_valid) begin
        out_item <= skid_item;
      end else if (accept) begin
        out_item <= res;
      end
    end else if (accept) begin
      skid_item <= res;
    end
  end

  assign scl_out   = out_item.scl_out;
  assign sda_out   = out_item.sda_out;
  assign ready_res = out_item.ready_res;
  assign done_res  = out_item.done_res;
  assign rx_byte   = out_item.rx_byte;
  assign ack_seen  = out_item.ack_seen;

endmodule

@@ hw/rtl/i2cbm_core.sv @@
// Bus sequencer of the I2C bit-level master: one tick per accepted item.
// Holds the phase, counters, shift register and pin levels; gives the tick's result.
// Depends on i2cbm_pkg.
module i2cbm_core (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            tick,
  input  logic [i2cbm_pkg::REQ_W-1:0]     req_type,
  input  logic [i2cbm_pkg::BYTE_W-1:0]    tx_byte,
  input  logic                            send_ack,
  input  logic                            sda_in,
  input  logic [i2cbm_pkg::HOLD_W-1:0]    hold_ticks,
  output i2cbm_pkg::result_t              res
);
  import i2cbm_pkg::*;

  // Sequencer state
  phase_t            phase;
  logic [3:0]        bit_count;
  logic [BYTE_W-1:0] shift_byte;
  logic [HOLD_W-1:0] wait_count;
  logic              ack_flag;
  logic              ack_drive;
  logic              scl_lvl;
  logic              sda_lvl;
  logic [BYTE_W-1:0] rx_reg;

  // Effective state after command decode
  phase_t            cur_phase;
  logic [3:0]        bc;
  logic [BYTE_W-1:0] sb;
  logic [HOLD_W-1:0] wc;
  logic              ad;

  // Next values
  phase_t            phase_next;
  logic [3:0]        bit_count_next;
  logic [BYTE_W-1:0] shift_byte_next;
  logic [HOLD_W-1:0] wait_count_next;
  logic              ack_flag_next;
  logic              ack_drive_next;
  logic              scl_lvl_next;
  logic              sda_lvl_next;
  logic [BYTE_W-1:0] rx_reg_next;
  logic              done;

  // Hold counter helpers
  logic [HOLD_W:0]   wait_inc;
  logic              hold_done;
  logic [HOLD_W-1:0] wait_held;
  logic [3:0]        bc_inc;
  logic              last_bit;

  // Command decode: only taken while idle
  always_comb begin
    cur_phase = phase;
    bc        = bit_count;
    sb        = shift_byte;
    wc        = wait_count;
    ad        = ack_drive;
    if (phase == P_IDLE) begin
      bc = '0;
      wc = '0;
      unique case (req_type)
        REQ_START: begin
          cur_phase = ST_SDA1;
        end
        REQ_WRITE: begin
          sb        = tx_byte;
          cur_phase = WR_BIT;
        end
        REQ_READ: begin
          sb        = '0;
          ad        = send_ack;
          cur_phase = RD_SCL1;
        end
        REQ_STOP: begin
          cur_phase = SP_SCL0;
        end
        default: begin
          cur_phase = P_IDLE;
        end
      endcase
    end
  end

  // Hold timing: zero hold behaves as one tick
  assign wait_inc  = {1'b0, wc} + {{HOLD_W{1'b0}}, 1'b1};
  assign hold_done = (wait_inc >= {1'b0, hold_ticks});
  assign wait_held = hold_done ? '0 : wait_inc[HOLD_W-1:0];
  assign bc_inc    = bc + 4'd1;
  assign last_bit  = (bc_inc >= BITS_PER_BYTE);

  // Next phase
  always_comb begin
    unique case (cur_phase)
      P_IDLE:   phase_next = P_IDLE;
      ST_SDA1:  phase_next = ST_SCL1;
      ST_SCL1:  phase_next = ST_W1;
      ST_W1:    phase_next = hold_done ? ST_SDA0 : ST_W1;
      ST_SDA0:  phase_next = ST_W2;
      ST_W2:    phase_next = hold_done ? ST_SCL0 : ST_W2;
      ST_SCL0:  phase_next = P_IDLE;
      WR_BIT:   phase_next = WR_SCL1;
      WR_SCL1:  phase_next = WR_W;
      WR_W:     phase_next = hold_done ? WR_SCL0 : WR_W;
      WR_SCL0:  phase_next = last_bit ? WR_REL : WR_BIT;
      WR_REL:   phase_next = WR_ASCL1;
      WR_ASCL1: phase_next = WR_AW;
      WR_AW:    phase_next = hold_done ? WR_ASCL0 : WR_AW;
      WR_ASCL0: phase_next = WR_TW;
      WR_TW:    phase_next = hold_done ? P_IDLE : WR_TW;
      RD_SCL1:  phase_next = RD_W;
      RD_W:     phase_next = hold_done ? RD_SCL0 : RD_W;
      RD_SCL0:  phase_next = last_bit ? RD_ACK : RD_SCL1;
      RD_ACK:   phase_next = RD_ASCL1;
      RD_ASCL1: phase_next = RD_AW;
      RD_AW:    phase_next = hold_done ? RD_ASCL0 : RD_AW;
      RD_ASCL0: phase_next = RD_REL;
      RD_REL:   phase_next = P_IDLE;
      SP_SCL0:  phase_next = SP_SDA0;
      SP_SDA0:  phase_next = SP_W1;
      SP_W1:    phase_next = hold_done ? SP_SCL1 : SP_W1;
      SP_SCL1:  phase_next = SP_W2;
      SP_W2:    phase_next = hold_done ? SP_SDA1 : SP_W2;
      SP_SDA1:  phase_next = P_IDLE;
      default:  phase_next = P_IDLE;
    endcase
  end

  // Pin levels, counters and flags for this tick
  always_comb begin
    scl_lvl_next    = scl_lvl;
    sda_lvl_next    = sda_lvl;
    bit_count_next  = bc;
    shift_byte_next = sb;
    wait_count_next = wc;
    ack_flag_next   = ack_flag;
    ack_drive_next  = ad;
    rx_reg_next     = rx_reg;
    done            = 1'b0;
    unique case (cur_phase)
      ST_SDA1: sda_lvl_next = 1'b1;
      ST_SCL1: begin
        scl_lvl_next    = 1'b1;
        wait_count_next = '0;
      end
      ST_W1, ST_W2, WR_W, WR_AW, RD_W, RD_AW, SP_W1, SP_W2: begin
        wait_count_next = wait_held;
      end
      ST_SDA0: begin
        sda_lvl_next    = 1'b0;
        wait_count_next = '0;
      end
      ST_SCL0: begin
        scl_lvl_next = 1'b0;
        done         = 1'b1;
      end
      WR_BIT: sda_lvl_next = sb[BYTE_W-1];
      WR_SCL1, WR_ASCL1, RD_SCL1, RD_ASCL1: begin
        scl_lvl_next    = 1'b1;
        wait_count_next = '0;
      end
      WR_SCL0: begin
        scl_lvl_next    = 1'b0;
        shift_byte_next = {sb[BYTE_W-2:0], 1'b0};
        bit_count_next  = bc_inc;
      end
      WR_REL: sda_lvl_next = 1'b1;
      WR_ASCL0: begin
        ack_flag_next   = ~sda_in;
        scl_lvl_next    = 1'b0;
        wait_count_next = '0;
      end
      WR_TW: begin
        wait_count_next = wait_held;
        done            = hold_done;
      end
      RD_SCL0: begin
        shift_byte_next = {sb[BYTE_W-2:0], sda_in};
        scl_lvl_next    = 1'b0;
        bit_count_next  = bc_inc;
      end
      RD_ACK:   sda_lvl_next = ~ad;
      RD_ASCL0: scl_lvl_next = 1'b0;
      RD_REL: begin
        sda_lvl_next = 1'b1;
        rx_reg_next  = sb;
        done         = 1'b1;
      end
      SP_SCL0: scl_lvl_next = 1'b0;
      SP_SDA0: begin
        sda_lvl_next    = 1'b0;
        wait_count_next = '0;
      end
      SP_SCL1: begin
        scl_lvl_next    = 1'b1;
        wait_count_next = '0;
      end
      SP_SDA1: begin
        sda_lvl_next = 1'b1;
        done         = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // Result of this tick
  always_comb begin
    res.scl_out   = scl_lvl_next;
    res.sda_out   = sda_lvl_next;
    res.ready_res = (phase_next == P_IDLE);
    res.done_res  = done;
    res.rx_byte   = rx_reg_next;
    res.ack_seen  = ack_flag_next;
  end

  // State update on each accepted item
  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= P_IDLE;
      bit_count  <= '0;
      shift_byte <= '0;
      wait_count <= '0;
      ack_flag   <= 1'b0;
      ack_drive  <= 1'b0;
      scl_lvl    <= 1'b1;
      sda_lvl    <= 1'b1;
      rx_reg     <= '0;
    end else if (tick) begin
      phase      <= phase_next;
      bit_count  <= bit_count_next;
      shift_byte <= shift_byte_next;
      wait_count <= wait_count_next;
      ack_flag   <= ack_flag_next;
      ack_drive  <= ack_drive_next;
      scl_lvl    <= scl_lvl_next;
      sda_lvl    <= sda_lvl_next;
      rx_reg     <= rx_reg_next;
    end
  end

endmodule
